/* hw/rtl/lidar_obstacle_avoid_sequencer_assert.svh */
// assertion macros for the obstacle avoidance sequencer
`ifndef LIDAR_OBSTACLE_AVOID_SEQUENCER_ASSERT_SVH
`define LIDAR_OBSTACLE_AVOID_SEQUENCER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LOAS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define LOAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/loas_pkg.sv */
// shared types and constants of the obstacle avoidance sequencer
package loas_pkg;

    localparam int DEFAULT_HISTORY_DEPTH = 64;

    typedef struct packed {
        logic [15:0] range_mm;
        logic [8:0]  beam_angle;
        logic        scan_end;
    } loas_in_t;

    typedef struct packed {
        logic [1:0]         message_kind;
        logic [10:0]        linear_milli;
        logic signed [11:0] angular_milli;
        logic               last_message;
    } loas_out_t;

    localparam logic [1:0] MSG_VELOCITY = 2'd0;
    localparam logic [1:0] MSG_STOP     = 2'd1;
    localparam logic [1:0] MSG_START    = 2'd2;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_AVOID  = 3'd1;
    localparam logic [2:0] REG_NEAR   = 3'd2;
    localparam logic [2:0] REG_MID    = 3'd3;
    localparam logic [2:0] REG_LIMIT  = 3'd4;
    localparam logic [2:0] REG_CRUISE = 3'd5;

endpackage

/* hw/rtl/lidar_obstacle_avoid_sequencer.sv */
// Obstacle avoidance sequencer: takes one range sample per cycle while idle and tracks the
// nearest front obstacle and the lateral one. The scan end sample starts the decision
// sequencer: one restoring divider, one quotient bit per cycle, computes 500000/range and a
// reciprocal multiply gives 3*range/5; a zero range skips the divider, and in idle mode the
// decision emits nothing. Each decision is followed by up to three messages at one per cycle
// as the output register frees. The result register lets the next scan's samples enter while
// the last message still waits. Recorded turns sit in a history memory of HISTORY_DEPTH
// entries with a registered read port.
module lidar_obstacle_avoid_sequencer
    import loas_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  loas_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output loas_out_t m_data,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [1:0] MODE_PLAIN  = 2'd1;
    localparam logic [1:0] MODE_ASSIST = 2'd2;
    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_DIV, S_TURN, S_REPLAY, S_TAIL, S_EMIT
    } state_t;

    state_t state_reg;

    logic [1:0]  mode_reg;
    logic [15:0] avoid_reg, near_reg, mid_reg;
    logic [10:0] limit_reg, cruise_reg;

    logic [5:0]  half_reg;
    logic [15:0] fmin_range_reg;
    logic [8:0]  fmin_angle_reg;
    logic        front_seen_reg, lateral_seen_reg;
    logic [1:0]  side_reg;
    logic        righting_reg, fwd_done_reg;
    logic [5:0]  fwd_left_reg;
    logic [CW-1:0] turn_count_reg;

    // restoring divider
    logic [18:0] dvd_reg;
    logic [15:0] dvs_reg, rem_reg;
    logic [4:0]  div_cnt_reg;
    logic [16:0] rem_sh;
    logic        qbit;

    logic [33:0] lin_prod;
    logic [15:0] lin_quo;

    logic [10:0] mag_reg, lin_reg;
    logic signed [11:0] ang_reg;
    loas_out_t   msg_reg [3];
    logic [1:0]  n_reg, emit_reg;
    logic        m_valid_reg;
    loas_out_t   m_data_reg;

    logic signed [11:0] hist_mem [HISTORY_DEPTH];
    logic signed [11:0] hist_rd_reg;
    logic [CW-1:0] count_dec;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          hist_we;
    logic signed [11:0] turn_ang;

    logic [8:0] lo_edge, hi_edge;
    logic       in_front, in_lateral, accept, left;
    logic [1:0] n_fin;

    function automatic loas_out_t mk_msg(logic [1:0] kind, logic [10:0] lin,
                                         logic signed [11:0] ang);
        loas_out_t m;
        m.message_kind  = kind;
        m.linear_milli  = lin;
        m.angular_milli = ang;
        m.last_message  = 1'b0;
        return m;
    endfunction

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign lo_edge = 9'd180 - {3'd0, half_reg};
    assign hi_edge = 9'd180 + {3'd0, half_reg};
    assign in_front = (s_data.beam_angle >= lo_edge) && (s_data.beam_angle < hi_edge)
        && (s_data.range_mm < fmin_range_reg);
    assign in_lateral = (s_data.range_mm < avoid_reg) &&
        ((side_reg == SIDE_LEFT && s_data.beam_angle >= 9'd75 && s_data.beam_angle < 9'd105)
        || (side_reg == SIDE_RIGHT && s_data.beam_angle >= 9'd255
            && s_data.beam_angle < 9'd285));

    assign rem_sh = {rem_reg, dvd_reg[18]};
    assign qbit   = (rem_sh >= {1'b0, dvs_reg});

    // 3 * range / 5 as range * 157287 >> 18, exact for 16-bit ranges
    assign lin_prod = {18'd0, fmin_range_reg} * 34'd157287;
    assign lin_quo  = lin_prod[33:18];

    assign count_dec = turn_count_reg - CW'(1);
    assign rd_addr   = count_dec[AW-1:0];
    assign wr_addr   = turn_count_reg[AW-1:0];
    assign left      = (side_reg == SIDE_LEFT) || (fmin_angle_reg <= 9'd180);
    assign turn_ang  = left ? $signed({1'b0, mag_reg}) : -$signed({1'b0, mag_reg});
    assign hist_we   = (state_reg == S_TURN) && (turn_count_reg < CW'(HISTORY_DEPTH));
    assign n_fin     = (mode_reg == MODE_PLAIN) ? n_reg + 2'd1 : n_reg;

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[wr_addr] <= turn_ang;
        end
        hist_rd_reg <= hist_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            mode_reg         <= MODE_ASSIST;
            avoid_reg        <= 16'd1500;
            near_reg         <= 16'd600;
            mid_reg          <= 16'd1000;
            limit_reg        <= 11'd800;
            cruise_reg       <= 11'd300;
            half_reg         <= 6'd15;
            fmin_range_reg   <= 16'd1500;
            fmin_angle_reg   <= '0;
            front_seen_reg   <= 1'b0;
            lateral_seen_reg <= 1'b0;
            side_reg         <= SIDE_NONE;
            righting_reg     <= 1'b0;
            fwd_done_reg     <= 1'b0;
            fwd_left_reg     <= 6'd26;
            turn_count_reg   <= '0;
            n_reg            <= '0;
            emit_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MODE:   mode_reg   <= cfg_wdata[1:0];
                    REG_AVOID:  avoid_reg  <= cfg_wdata;
                    REG_NEAR:   near_reg   <= cfg_wdata;
                    REG_MID:    mid_reg    <= cfg_wdata;
                    REG_LIMIT:  limit_reg  <= cfg_wdata[10:0];
                    REG_CRUISE: cruise_reg <= cfg_wdata[10:0];
                    default: ;
                endcase
            end
            // while emitting, the emit state reloads the word itself
            if (m_valid_reg && m_ready && state_reg != S_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (in_front) begin
                            fmin_range_reg <= s_data.range_mm;
                            fmin_angle_reg <= s_data.beam_angle;
                            front_seen_reg <= 1'b1;
                        end
                        if (in_lateral) begin
                            lateral_seen_reg <= 1'b1;
                        end
                        if (s_data.scan_end) begin
                            state_reg <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    n_reg   <= '0;
                    ang_reg <= '0;
                    lin_reg <= '0;
                    if (mode_reg != MODE_PLAIN && mode_reg != MODE_ASSIST) begin
                        fmin_range_reg   <= avoid_reg;
                        fmin_angle_reg   <= '0;
                        front_seen_reg   <= 1'b0;
                        lateral_seen_reg <= 1'b0;
                        state_reg        <= S_IDLE;
                    end else begin
                        if (fmin_range_reg < near_reg) begin
                            half_reg <= 6'd42;
                        end else if (fmin_range_reg < mid_reg) begin
                            half_reg <= 6'd30;
                        end else begin
                            half_reg <= 6'd15;
                        end
                        if (front_seen_reg && !righting_reg) begin
                            if (fmin_range_reg == '0) begin
                                mag_reg   <= limit_reg;
                                state_reg <= S_TURN;
                            end else begin
                                dvd_reg     <= 19'd500000;
                                dvs_reg     <= fmin_range_reg;
                                rem_reg     <= '0;
                                div_cnt_reg <= 5'd18;
                                state_reg   <= S_DIV;
                            end
                        end else if (side_reg == SIDE_LEFT || side_reg == SIDE_RIGHT) begin
                            if (!fwd_done_reg) begin
                                if (fwd_left_reg == '0) begin
                                    fwd_done_reg <= 1'b1;
                                end else begin
                                    fwd_left_reg <= fwd_left_reg - 6'd1;
                                end
                                righting_reg <= 1'b1;
                                msg_reg[0]   <= mk_msg(MSG_VELOCITY, cruise_reg, '0);
                                n_reg        <= 2'd1;
                                state_reg    <= S_TAIL;
                            end else if (turn_count_reg == '0) begin
                                if (lateral_seen_reg && !front_seen_reg) begin
                                    msg_reg[0] <= mk_msg(MSG_VELOCITY, cruise_reg, '0);
                                    msg_reg[1] <= mk_msg(MSG_VELOCITY, cruise_reg, '0);
                                    n_reg      <= 2'd2;
                                end else begin
                                    righting_reg <= 1'b0;
                                    side_reg     <= SIDE_NONE;
                                    fwd_left_reg <= 6'd25;
                                    fwd_done_reg <= 1'b0;
                                    if (mode_reg == MODE_ASSIST) begin
                                        msg_reg[0] <= mk_msg(MSG_START, '0, '0);
                                        msg_reg[1] <= mk_msg(MSG_VELOCITY, '0, '0);
                                        n_reg      <= 2'd2;
                                    end else begin
                                        msg_reg[0] <= mk_msg(MSG_VELOCITY, '0, '0);
                                        n_reg      <= 2'd1;
                                    end
                                end
                                state_reg <= S_TAIL;
                            end else begin
                                // history read issued this cycle at count - 1
                                turn_count_reg <= count_dec;
                                state_reg      <= S_REPLAY;
                            end
                        end else begin
                            state_reg <= S_TAIL;
                        end
                    end
                end
                S_DIV: begin
                    if (qbit) begin
                        rem_reg <= rem_sh[15:0] - dvs_reg;
                    end else begin
                        rem_reg <= rem_sh[15:0];
                    end
                    dvd_reg <= {dvd_reg[17:0], qbit};
                    if (div_cnt_reg != '0) begin
                        div_cnt_reg <= div_cnt_reg - 5'd1;
                    end else begin
                        if ({dvd_reg[17:0], qbit} > {8'd0, limit_reg}) begin
                            mag_reg <= limit_reg;
                        end else begin
                            mag_reg <= {dvd_reg[9:0], qbit};
                            lin_reg <= (lin_quo > 16'd2000) ? 11'd2000 : lin_quo[10:0];
                        end
                        state_reg <= S_TURN;
                    end
                end
                S_TURN: begin
                    if (turn_count_reg < CW'(HISTORY_DEPTH)) begin
                        turn_count_reg <= turn_count_reg + CW'(1);
                    end
                    side_reg <= left ? SIDE_LEFT : SIDE_RIGHT;
                    ang_reg  <= turn_ang;
                    if (mode_reg == MODE_ASSIST) begin
                        msg_reg[0] <= mk_msg(MSG_STOP, '0, '0);
                        msg_reg[1] <= mk_msg(MSG_VELOCITY, lin_reg, turn_ang);
                        n_reg      <= 2'd2;
                    end else begin
                        msg_reg[0] <= mk_msg(MSG_VELOCITY, lin_reg, turn_ang);
                        n_reg      <= 2'd1;
                    end
                    state_reg <= S_TAIL;
                end
                S_REPLAY: begin
                    ang_reg    <= -hist_rd_reg;
                    msg_reg[0] <= mk_msg(MSG_VELOCITY, '0, -hist_rd_reg);
                    n_reg      <= 2'd1;
                    state_reg  <= S_TAIL;
                end
                S_TAIL: begin
                    if (mode_reg == MODE_PLAIN) begin
                        msg_reg[n_reg] <= mk_msg(MSG_VELOCITY, cruise_reg, ang_reg);
                    end
                    n_reg            <= n_fin;
                    emit_reg         <= '0;
                    fmin_range_reg   <= avoid_reg;
                    fmin_angle_reg   <= '0;
                    front_seen_reg   <= 1'b0;
                    lateral_seen_reg <= 1'b0;
                    state_reg        <= (n_fin == '0) ? S_IDLE : S_EMIT;
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_data_reg   <= {msg_reg[emit_reg][$bits(loas_out_t)-1:1],
                                         emit_reg == n_reg - 2'd1};
                        emit_reg     <= emit_reg + 2'd1;
                        if (emit_reg == n_reg - 2'd1) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/loas_checker.sv */
// port level checks of the obstacle avoidance sequencer and their binding
`include "lidar_obstacle_avoid_sequencer_assert.svh"

module loas_checker
    import loas_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input loas_in_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input loas_out_t m_data
);

    logic kind_ok, trace_msg, no_motion, mid_acc;

    assign kind_ok   = (m_data.message_kind == MSG_VELOCITY)
        || (m_data.message_kind == MSG_STOP) || (m_data.message_kind == MSG_START);
    assign trace_msg = m_valid && (m_data.message_kind != MSG_VELOCITY);
    assign no_motion = (m_data.linear_milli == '0) && (m_data.angular_milli == '0);
    assign mid_acc   = s_valid && s_ready && !s_data.scan_end;

    // a stalled result word holds
    `LOAS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // only defined message kinds leave the block
    `LOAS_ASSERT_NOW(a_kind, aclk, aresetn, m_valid, kind_ok)
    // tracing messages carry no motion
    `LOAS_ASSERT_NOW(a_trace_zero, aclk, aresetn, trace_msg, no_motion)
    // a mid-scan sample never stalls the next one
    `LOAS_ASSERT_NEXT(a_mid_scan, aclk, aresetn, mid_acc, s_ready)

endmodule

bind lidar_obstacle_avoid_sequencer loas_checker u_loas_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* sim/tb_lidar_obstacle_avoid_sequencer.sv */
// testbench for the lidar obstacle avoidance sequencer with a scan decision predictor
module tb_lidar_obstacle_avoid_sequencer;
    timeunit 1ns;
    timeprecision 1ps;
    import loas_pkg::*;

    localparam int HIST = 64;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    loas_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    loas_out_t   m_data;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;

    lidar_obstacle_avoid_sequencer #(.HISTORY_DEPTH(HIST)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // predictor copy of registers and decision state
    logic [1:0]         p_mode;
    logic [15:0]        p_avoid, p_near, p_mid;
    logic [10:0]        p_limit, p_cruise;
    int unsigned        win_w, fmin_rng, fmin_ang, fwd_left, turns, side;
    bit                 fseen, lat_seen, righting, fwd_done;
    logic signed [11:0] turn_log [HIST];

    loas_out_t expected_msgs[$];
    int errors;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic void open_scan();
        fmin_rng = p_avoid;
        fmin_ang = 0;
        fseen    = 0;
        lat_seen = 0;
    endfunction

    function automatic void queue_msg(input logic [1:0] kind, input int unsigned lin,
                                      input int ang);
        loas_out_t o;
        o.message_kind  = kind;
        o.linear_milli  = lin[10:0];
        o.angular_milli = ang[11:0];
        o.last_message  = 1'b0;
        expected_msgs.push_back(o);
    endfunction

    function automatic void predict_sample(input loas_in_t w);
        int unsigned r, a, half, q, lin, idx, n0;
        int ang;
        bit left;
        r = w.range_mm;
        a = w.beam_angle;
        half = win_w / 2;
        n0 = expected_msgs.size();
        if (a >= 180 - half && a < 180 + half && r < fmin_rng) begin
            fmin_rng = r;
            fmin_ang = a;
            fseen = 1;
        end
        if (r < p_avoid && ((side == 1 && a >= 75 && a < 105) ||
                            (side == 2 && a >= 255 && a < 285)))
            lat_seen = 1;
        if (!w.scan_end) return;
        if (p_mode == 2'd1 || p_mode == 2'd2) begin
            r = fmin_rng;
            ang = 0;
            lin = 0;
            if (r < p_near) win_w = 85;
            else if (r < p_mid) win_w = 60;
            else win_w = 30;
            if (fseen && !righting) begin
                q = (r == 0) ? 0 : 500000 / r;
                left = (side == 1) || (fmin_ang <= 180);
                if (r == 0 || q > p_limit) ang = p_limit;
                else begin
                    ang = q;
                    lin = (3 * r) / 5;
                    if (lin > 2000) lin = 2000;
                end
                if (!left) ang = -ang;
                if (turns < HIST) begin
                    turn_log[turns] = ang;
                    turns++;
                end
                side = left ? 1 : 2;
                if (p_mode == 2'd2) queue_msg(MSG_STOP, 0, 0);
                queue_msg(MSG_VELOCITY, lin, ang);
            end else if (side == 1 || side == 2) begin
                if (!fwd_done) begin
                    lin = p_cruise;
                    if (fwd_left == 0) fwd_done = 1;
                    else fwd_left--;
                    righting = 1;
                end else if (turns == 0) begin
                    if (lat_seen && !fseen) begin
                        lin = p_cruise;
                        queue_msg(MSG_VELOCITY, lin, 0);
                    end else begin
                        righting = 0;
                        side = 0;
                        fwd_left = 25;
                        fwd_done = 0;
                        if (p_mode == 2'd2) queue_msg(MSG_START, 0, 0);
                    end
                end else begin
                    idx = turns - 1;
                    ang = -turn_log[idx];
                    turns = idx;
                end
                queue_msg(MSG_VELOCITY, lin, ang);
            end
            if (p_mode == 2'd1) queue_msg(MSG_VELOCITY, p_cruise, ang);
            if (expected_msgs.size() > n0)
                expected_msgs[expected_msgs.size() - 1].last_message = 1'b1;
        end
        open_scan();
    endfunction

    // checker: compares every accepted word with the oldest expectation
    always @(posedge aclk) begin
        loas_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_msgs.size() == 0) begin
                report("unexpected word", m_data.message_kind, -1);
            end else begin
                e = expected_msgs.pop_front();
                if (m_data.message_kind !== e.message_kind)
                    report("message_kind", m_data.message_kind, e.message_kind);
                if (m_data.linear_milli !== e.linear_milli)
                    report("linear_milli", m_data.linear_milli, e.linear_milli);
                if (m_data.angular_milli !== e.angular_milli)
                    report("angular_milli", m_data.angular_milli, e.angular_milli);
                if (m_data.last_message !== e.last_message)
                    report("last_message", m_data.last_message, e.last_message);
            end
        end
    end

    // receiver stalls: a fresh wait drawn for every word
    initial begin
        int n;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            n = $urandom_range(0, 14);
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    bit no_gaps;

    task automatic send_sample(input int unsigned r, input int unsigned a, input bit last);
        loas_in_t w;
        int n;
        w.range_mm   = r[15:0];
        w.beam_angle = a[8:0];
        w.scan_end   = last;
        n = no_gaps ? 0 : $urandom_range(0, 14);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_sample(w);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_msgs.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MODE:   p_mode   = v[1:0];
            REG_AVOID:  p_avoid  = v;
            REG_NEAR:   p_near   = v;
            REG_MID:    p_mid    = v;
            REG_LIMIT:  p_limit  = v[10:0];
            REG_CRUISE: p_cruise = v[10:0];
            default: ;
        endcase
    endtask

    // one compressed scan: a front sample, a lateral sample, then the scan end
    task automatic send_scan(input int unsigned fr, input int unsigned fa,
                             input int unsigned lr);
        send_sample(fr, fa, 0);
        send_sample(lr, (side == 2) ? $urandom_range(255, 284) : $urandom_range(75, 104), 0);
        send_sample($urandom_range(0, 65535), $urandom_range(0, 359), 1);
    endtask

    task automatic test_directed();
        send_sample(0, 180, 0);
        send_sample(65535, 511, 1);
        send_sample(65535, 359, 0);
        send_sample(0, 0, 1);
        send_sample(300, 170, 1);
        send_sample(1200, 190, 1);
        send_sample(900, 200, 1);
        send_sample(400, 100, 0);
        send_sample(5000, 181, 1);
    endtask

    // full episode: turns, forward run, replay, lateral wait, then end
    task automatic test_episode(input int nturns);
        int i;
        for (i = 0; i < nturns; i++)
            send_scan($urandom_range(0, 1499), $urandom_range(166, 194),
                      $urandom_range(0, 65535));
        // forward run and replay, one sample per scan
        for (i = 0; i < 27 + nturns; i++)
            send_sample(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1499) : 60000,
                        $urandom_range(150, 210), 1);
        for (i = 0; i < 3; i++)
            send_scan(60000, $urandom_range(150, 210), $urandom_range(0, 3000));
    endtask

    task automatic test_config_sweep();
        drain();
        write_reg(REG_MODE, 16'd1);
        write_reg(REG_LIMIT, 16'd2000);
        write_reg(REG_CRUISE, 16'd2000);
        write_reg(REG_AVOID, 16'd65535);
        write_reg(REG_NEAR, 16'd0);
        write_reg(REG_MID, 16'd65535);
        send_sample(65534, 180, 1);
        send_sample(200, 175, 1);
        test_episode(1);
        drain();
        write_reg(REG_MODE, 16'd0);
        send_sample(100, 180, 1);
        drain();
        write_reg(3'd7, 16'hFFFF);
        send_sample(100, 180, 1);
        drain();
        write_reg(REG_MODE, 16'd3);
        send_sample(100, 180, 1);
        drain();
        write_reg(REG_MODE, 16'd2);
        write_reg(REG_LIMIT, 16'd0);
        write_reg(REG_CRUISE, 16'd0);
        write_reg(REG_AVOID, 16'd0);
        send_sample(0, 180, 1);
        send_sample(50, 175, 1);
        send_sample(3000, 90, 1);
        drain();
        write_reg(REG_AVOID, 16'd1500);
        write_reg(REG_NEAR, 16'd600);
        write_reg(REG_MID, 16'd1000);
        write_reg(REG_LIMIT, 16'd800);
        write_reg(REG_CRUISE, 16'd300);
    endtask

    task automatic test_random();
        int i;
        for (i = 0; i < 20; i++) begin
            no_gaps = (i >= 10);
            send_sample($urandom_range(0, 65535), $urandom_range(0, 359),
                        $urandom_range(0, 3) == 0);
        end
        no_gaps = 0;
        drain();
    endtask

    initial begin
        errors = 0;
        no_gaps = 0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        p_mode = 2'd2;
        p_avoid = 16'd1500;
        p_near = 16'd600;
        p_mid = 16'd1000;
        p_limit = 11'd800;
        p_cruise = 11'd300;
        win_w = 30;
        side = 0;
        righting = 0;
        fwd_left = 26;
        fwd_done = 0;
        turns = 0;
        open_scan();
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_episode(2);
        test_config_sweep();
        test_random();
        drain();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/loas_pkg.sv
hw/rtl/lidar_obstacle_avoid_sequencer.sv
hw/rtl/loas_checker.sv
sim/tb_lidar_obstacle_avoid_sequencer.sv
